[hw/rtl/reversible_deque_defines.svh]
// Assertion macros shared by the reversible deque RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef REVERSIBLE_DEQUE_DEFINES_SVH
`define REVERSIBLE_DEQUE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RDQ_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rdq: assertion failed");
// next-cycle implication
`define RDQ_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rdq: assertion failed");
`else
`define RDQ_ASSERT_SAME(lbl, ant, cons)
`define RDQ_ASSERT_NEXT(lbl, ant, cons)
`endif
`endif

[hw/rtl/rdq_pkg.sv]
// Shared types and constants for the reversible deque.
// No dependencies.
`default_nettype none
package rdq_pkg;

  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_WIDTH      = 3;
  localparam int STATUS_WIDTH   = 2;

  typedef enum logic [CMD_WIDTH-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REVERSE    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;   // input transfer this cycle
    logic    load;     // capture read data and result snapshot
    logic    push;     // push that will be stored
    logic    pop;      // pop on a non-empty deque
    logic    at_head;  // physical head end is the target
    logic    toggle;   // flip orientation
    status_t status;   // status of the accepted command
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic reversed;
    logic empty;
    logic full;
  } sts_t;

endpackage
`default_nettype wire

[hw/rtl/reversible_deque.sv]
// Top level of the reversible deque: ring-store double-ended queue with reverse flag.
// Depends on rdq_pkg, rdq_ctrl, rdq_datapath (and rdq_ring_mem below it).
//
//  channel | ports                                            | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, in_cmd, in_value             | to block
//  out     | out_valid, out_stall, out_front_value,           | from block
//          | out_back_value, out_occupancy, out_status        |
//
// Each command has an accept cycle, which updates head/count/orientation and
// writes the ring store, and then a read in S_READ, which reads both ends
// through the store's registered read ports into the result registers.
// The result register is separate from the input side, so a new command is
// taken while an earlier result still waits on out_stall; the read cycle
// waits until the result register is free.
// Reset (rst_n low, synchronous) empties the deque; store contents are not cleared.
`default_nettype none
module reversible_deque #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic        [rdq_pkg::CMD_WIDTH-1:0]  in_cmd,
  input  wire logic signed [DATA_WIDTH-1:0]          in_value,
  // result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed      [DATA_WIDTH-1:0]          out_front_value,
  output logic signed      [DATA_WIDTH-1:0]          out_back_value,
  output logic             [$clog2(DEPTH+1)-1:0]     out_occupancy,
  output logic             [rdq_pkg::STATUS_WIDTH-1:0] out_status
);

  // command bundle from controller, flags back from datapath
  rdq_pkg::ctl_t ctl;
  rdq_pkg::sts_t sts;

  rdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_value        (in_value),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_status      (out_status)
  );

endmodule
`default_nettype wire

[hw/rtl/rdq_ring_mem.sv]
// Ring store: one write port, two registered read ports.
// Depends on rdq_pkg for parameter defaults.
`default_nettype none
module rdq_ring_mem #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  wire logic [DATA_WIDTH-1:0]        wr_data,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0]     rd_addr_b,
  output logic      [DATA_WIDTH-1:0]        rd_data_a,
  output logic      [DATA_WIDTH-1:0]        rd_data_b
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rdq_datapath.sv]
// Deque datapath: head/count/orientation registers, ring store, result registers.
// Depends on rdq_pkg and rdq_ring_mem.
`default_nettype none
`include "reversible_deque_defines.svh"
module rdq_datapath #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rdq_pkg::ctl_t                      ctl,
  output rdq_pkg::sts_t                           sts,
  input  wire logic signed [DATA_WIDTH-1:0]       in_value,
  output logic signed      [DATA_WIDTH-1:0]       out_front_value,
  output logic signed      [DATA_WIDTH-1:0]       out_back_value,
  output logic             [$clog2(DEPTH+1)-1:0]  out_occupancy,
  output logic             [rdq_pkg::STATUS_WIDTH-1:0] out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;
  rdq_pkg::status_t status_r;

  logic [CW-1:0] out_count_r;
  logic          out_rev_r;
  rdq_pkg::status_t out_status_r;

  logic [AW-1:0] head_inc, head_dec, back_pos, tail_pos, wr_addr;
  logic [SW-1:0] back_sum;
  logic [DATA_WIDTH-1:0] head_q, tail_q;
  logic          out_empty;

  // ring arithmetic; count < DEPTH on a push so back_sum < 2*DEPTH
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign back_sum = SW'(head_r) + SW'(count_r);
  assign back_pos = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
  assign tail_pos = (back_pos == '0) ? AW'(DEPTH - 1) : back_pos - AW'(1);
  assign wr_addr  = ctl.at_head ? head_dec : back_pos;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    if (ctl.accept) begin
      if (ctl.push) begin
        count_nxt = count_r + CW'(1);
        if (ctl.at_head) begin
          head_nxt = head_dec;
        end
      end
      if (ctl.pop) begin
        count_nxt = count_r - CW'(1);
        if (ctl.at_head) begin
          head_nxt = head_inc;
        end
      end
      if (ctl.toggle) begin
        rev_nxt = ~rev_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

  // status and result snapshot
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      status_r <= ctl.status;
    end
    if (ctl.load) begin
      out_count_r  <= count_r;
      out_rev_r    <= rev_r;
      out_status_r <= status_r;
    end
  end

  rdq_ring_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk       (clk),
    .wr_en     (ctl.accept && ctl.push),
    .wr_addr   (wr_addr),
    .wr_data   (in_value),
    .rd_en     (ctl.load),
    .rd_addr_a (head_r),
    .rd_addr_b (tail_pos),
    .rd_data_a (head_q),
    .rd_data_b (tail_q)
  );

  assign out_empty       = (out_count_r == '0);
  assign out_front_value = out_empty ? '0 : (out_rev_r ? tail_q : head_q);
  assign out_back_value  = out_empty ? '0 : (out_rev_r ? head_q : tail_q);
  assign out_occupancy   = out_count_r;
  assign out_status      = out_status_r;

  assign sts.reversed = rev_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r == CW'(DEPTH));

  `RDQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `RDQ_ASSERT_NEXT(a_push_count, ctl.accept && ctl.push, count_r == $past(count_r) + CW'(1))
  `RDQ_ASSERT_NEXT(a_pop_head, ctl.accept && ctl.pop && ctl.at_head, head_r == $past(head_inc))

endmodule
`default_nettype wire

[hw/rtl/rdq_ctrl.sv]
// Deque controller: accept/read sequencing, command decode, output valid.
// Depends on rdq_pkg.
`default_nettype none
`include "reversible_deque_defines.svh"
module rdq_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [rdq_pkg::CMD_WIDTH-1:0]   in_cmd,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  input  wire rdq_pkg::sts_t                   sts,
  output rdq_pkg::ctl_t                        ctl
);

  rdq_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic push_req, pop_req, at_head, toggle;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rdq_pkg::S_READ;
        end
      end
      rdq_pkg::S_READ: begin
        if (out_free) begin
          state_nxt = rdq_pkg::S_IDLE;
        end
      end
      default: state_nxt = rdq_pkg::S_IDLE;
    endcase
  end

  // outputs and decode
  always_comb begin
    push_req = 1'b0;
    pop_req  = 1'b0;
    at_head  = 1'b0;
    toggle   = 1'b0;
    unique case (in_cmd)
      rdq_pkg::CMD_PUSH_FRONT: begin
        push_req = 1'b1;
        at_head  = !sts.reversed;
      end
      rdq_pkg::CMD_PUSH_BACK: begin
        push_req = 1'b1;
        at_head  = sts.reversed;
      end
      rdq_pkg::CMD_POP_FRONT: begin
        pop_req = 1'b1;
        at_head = !sts.reversed;
      end
      rdq_pkg::CMD_POP_BACK: begin
        pop_req = 1'b1;
        at_head = sts.reversed;
      end
      rdq_pkg::CMD_REVERSE: begin
        toggle = 1'b1;
      end
      default: begin
        toggle = 1'b0;
      end
    endcase

    in_stall       = (state_r != rdq_pkg::S_IDLE);
    ctl.accept     = in_valid && (state_r == rdq_pkg::S_IDLE);
    ctl.load       = (state_r == rdq_pkg::S_READ) && out_free;
    ctl.push       = push_req && !sts.full;
    ctl.pop        = pop_req && !sts.empty;
    ctl.at_head    = at_head;
    ctl.toggle     = toggle;
    if (pop_req && sts.empty) begin
      ctl.status = rdq_pkg::ST_EMPTY;
    end else if (push_req && sts.full) begin
      ctl.status = rdq_pkg::ST_FULL;
    end else begin
      ctl.status = rdq_pkg::ST_OK;
    end

    out_valid_nxt = ctl.load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdq_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `RDQ_ASSERT_NEXT(a_accept_to_read, ctl.accept, state_r == rdq_pkg::S_READ)
  `RDQ_ASSERT_SAME(a_valid_from_read, $rose(out_valid_r), $past(state_r) == rdq_pkg::S_READ)

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for reversible_deque: directed and random deque commands
// with a cycle-free model of the ring store that predicts every result.
// Depends on rdq_pkg and the reversible_deque RTL.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = 256;
  localparam int DW             = 32;
  localparam int AW             = $clog2(DEPTH);
  localparam int OCC_W          = $clog2(DEPTH + 1);
  localparam int CW             = rdq_pkg::CMD_WIDTH;
  localparam int N_ITEMS        = 1750;
  localparam int QUIET_LIMIT    = 2000;  // cycles with no transfer on either channel
  localparam int RX_HOLD_CYCLES = 300;   // long result-side hold-off, fills the block
  localparam int SETTLE_CYCLES  = 8;     // settle time after the last result

  // codes the block must treat as no-ops
  localparam logic [CW-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CW-1:0] CMD_SPARE_MID   = 3'd6;
  localparam logic [CW-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [DW-1:0] W_MAX = 32'h7fff_ffff;
  localparam logic [DW-1:0] W_MIN = 32'h8000_0000;

  // idle profile of the run: receiver slow, then sender slow, then full rate
  typedef enum logic [1:0] {
    PH_RX_SLOW = 2'd0,
    PH_TX_SLOW = 2'd1,
    PH_NO_IDLE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CW-1:0] cmd;
    logic [DW-1:0] value;
    logic          drain;  // wait for every result before offering
    logic          hold;   // receiver holds off once this one transfers
    phase_t        phase;
  } cmd_item_t;

  typedef struct packed {
    logic [DW-1:0]     front;
    logic [DW-1:0]     back;
    logic [OCC_W-1:0]  occ;
    rdq_pkg::status_t  status;
  } ends_t;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic [CW-1:0]        in_cmd        = '0;
  logic signed [DW-1:0] in_value      = '0;
  logic                 out_stall     = 1'b0;
  // side-band marks that travel with the payload, seen by the monitor
  logic                 in_hold_mark  = 1'b0;
  phase_t               in_phase_mark = PH_RX_SLOW;

  wire logic                             in_stall;
  wire logic                             out_valid;
  wire logic signed [DW-1:0]             out_front_value;
  wire logic signed [DW-1:0]             out_back_value;
  wire logic [OCC_W-1:0]                 out_occupancy;
  wire logic [rdq_pkg::STATUS_WIDTH-1:0] out_status;

  initial begin
    forever #5 clk = ~clk;
  end

  // synchronous reset, asserted at the start and never again
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  reversible_deque #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_front_value (out_front_value),
    .out_back_value  (out_back_value),
    .out_occupancy   (out_occupancy),
    .out_status      (out_status)
  );

  // ---------------------------------------------------------------------------
  // Deque model: physical ring, head pointer, count, orientation flag.
  // Logical front is the physical head unless the orientation is flipped.
  // ---------------------------------------------------------------------------
  logic [DW-1:0]    ring_model [DEPTH];
  logic [AW-1:0]    model_head  = '0;
  logic [OCC_W-1:0] model_count = '0;
  logic             model_rev   = 1'b0;

  ends_t     ends_due [$];   // predicted results, oldest first
  cmd_item_t pending  [$];   // commands still to be offered

  int     tx_count  = 0;     // input transfers (driver only)
  int     rx_count  = 0;     // result transfers (monitor only)
  int     n_total   = 0;
  int     n_errors  = 0;
  int     hold_left = 0;
  int     quiet_cycles = 0;
  phase_t rx_phase  = PH_RX_SLOW;
  phase_t gen_phase = PH_RX_SLOW;

  function automatic rdq_pkg::status_t ring_push(input logic at_head,
                                                 input logic [DW-1:0] v);
    if (model_count >= DEPTH) return rdq_pkg::ST_FULL;  // dropped, nothing moves
    if (at_head) begin
      model_head = model_head - 1'b1;
      ring_model[model_head] = v;
    end else begin
      ring_model[AW'(model_head + model_count)] = v;
    end
    model_count = model_count + 1'b1;
    return rdq_pkg::ST_OK;
  endfunction

  function automatic rdq_pkg::status_t ring_pop(input logic at_head);
    if (model_count == 0) return rdq_pkg::ST_EMPTY;
    if (at_head) model_head = model_head + 1'b1;
    model_count = model_count - 1'b1;
    return rdq_pkg::ST_OK;
  endfunction

  // apply one accepted command and queue the result it must produce
  function automatic void deque_step(input logic [CW-1:0] cmd,
                                     input logic [DW-1:0] value);
    ends_t         r;
    logic [DW-1:0] head_word;
    logic [DW-1:0] tail_word;
    r.status = rdq_pkg::ST_OK;
    case (cmd)
      rdq_pkg::CMD_PUSH_FRONT: r.status = ring_push(!model_rev, value);
      rdq_pkg::CMD_PUSH_BACK:  r.status = ring_push(model_rev, value);
      rdq_pkg::CMD_POP_FRONT:  r.status = ring_pop(!model_rev);
      rdq_pkg::CMD_POP_BACK:   r.status = ring_pop(model_rev);
      rdq_pkg::CMD_REVERSE:    model_rev = !model_rev;
      default: ;      // spare codes: no state change, status ok
    endcase
    head_word = '0;
    tail_word = '0;
    if (model_count != 0) begin
      head_word = ring_model[model_head];
      tail_word = ring_model[AW'(model_head + model_count - 1'b1)];
    end
    r.front = model_rev ? tail_word : head_word;
    r.back  = model_rev ? head_word : tail_word;
    r.occ   = model_count;
    ends_due.insert(ends_due.size(), r);
  endfunction

  function automatic void check_field(input string name, input logic [DW-1:0] want,
                                      input logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endfunction

  function automatic int tx_idle_pct(input phase_t ph);
    case (ph)
      PH_RX_SLOW: return 38;
      PH_TX_SLOW: return 68;
      default:    return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(input phase_t ph);
    case (ph)
      PH_RX_SLOW: return 68;
      PH_TX_SLOW: return 38;
      default:    return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  // The phase follows the item's position in the run. The first item of each
  // later phase, and about one item in a hundred at random, waits for the block
  // to drain; the first full-rate item starts the long receiver hold-off.
  function automatic void add_item(input logic [CW-1:0] c, input logic [DW-1:0] v);
    cmd_item_t it;
    phase_t    ph;
    ph = (n_total < N_ITEMS / 3)     ? PH_RX_SLOW :
         (n_total < 2 * N_ITEMS / 3) ? PH_TX_SLOW : PH_NO_IDLE;
    it.cmd   = c;
    it.value = v;
    it.phase = ph;
    it.drain = (ph != gen_phase) || ($urandom_range(0, 99) == 0);
    it.hold  = (ph == PH_NO_IDLE) && (gen_phase != PH_NO_IDLE);
    gen_phase = ph;
    pending.insert(pending.size(), it);
    n_total++;
  endfunction

  // extremes show up often, the rest is a full random word
  function automatic logic [DW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return W_MAX;
      1:       return W_MIN;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int seg_len;
    int push_pct;
    int r;
    int fill_marks [$];
    logic [CW-1:0] c;

    // empty deque: pops flag, peeks are zero, reverse still toggles
    add_item(rdq_pkg::CMD_POP_FRONT, rand_word());
    add_item(rdq_pkg::CMD_POP_BACK, rand_word());
    add_item(rdq_pkg::CMD_REVERSE, '0);
    add_item(rdq_pkg::CMD_POP_FRONT, '0);
    add_item(rdq_pkg::CMD_REVERSE, '0);
    add_item(CMD_SPARE_FIRST, W_MAX);
    add_item(CMD_SPARE_MID, W_MIN);
    add_item(CMD_SPARE_LAST, '1);
    // push front from head zero wraps the pointer
    add_item(rdq_pkg::CMD_PUSH_FRONT, W_MAX);
    add_item(rdq_pkg::CMD_PUSH_BACK, W_MIN);
    add_item(rdq_pkg::CMD_PUSH_FRONT, '1);
    add_item(rdq_pkg::CMD_PUSH_BACK, '0);
    add_item(rdq_pkg::CMD_PUSH_FRONT, 32'h1);
    add_item(rdq_pkg::CMD_REVERSE, '0);
    add_item(rdq_pkg::CMD_POP_FRONT, '0);
    add_item(rdq_pkg::CMD_POP_BACK, '0);
    add_item(rdq_pkg::CMD_PUSH_FRONT, 32'h5555_5555);
    add_item(rdq_pkg::CMD_PUSH_BACK, 32'haaaa_aaaa);
    add_item(rdq_pkg::CMD_REVERSE, '0);
    add_item(rdq_pkg::CMD_POP_FRONT, '0);
    add_item(rdq_pkg::CMD_POP_BACK, '0);
    add_item(rdq_pkg::CMD_POP_FRONT, '0);
    add_item(rdq_pkg::CMD_POP_BACK, '0);
    add_item(rdq_pkg::CMD_POP_FRONT, '0);
    add_item(rdq_pkg::CMD_POP_BACK, '0);   // one pop past empty

    // Random part in segments with a push bias; two long push-heavy runs
    // drive the deque into full so that dropped pushes are exercised.
    fill_marks = '{400, 1250};
    while (n_total < N_ITEMS) begin
      if (fill_marks.size() != 0 && n_total >= fill_marks[0]) begin
        fill_marks.delete(0);
        seg_len  = 320;
        push_pct = 92;
      end else begin
        seg_len = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        if (r < push_pct)
          c = $urandom_range(0, 1) ? rdq_pkg::CMD_PUSH_BACK : rdq_pkg::CMD_PUSH_FRONT;
        else if (r < 96)
          c = $urandom_range(0, 1) ? rdq_pkg::CMD_POP_BACK : rdq_pkg::CMD_POP_FRONT;
        else if (r < 99)
          c = rdq_pkg::CMD_REVERSE;
        else
          c = CW'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        add_item(c, rand_word());
      end
    end

    // every command offered, every result back, then a short settle
    wait (tx_count == n_total);
    wait (rx_count == tx_count);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ends_due.size() != 0) begin
      $error("%0d expected results never arrived", ends_due.size());
      n_errors++;
    end
    if (n_errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers pending commands, holds a stalled payload steady.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    cmd_item_t nxt;
    logic      took;
    logic      offer;
    took  = in_valid && !in_stall;
    offer = 1'b0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        deque_step(in_cmd, in_value);
        tx_count <= tx_count + 1;
      end
      // a stalled transfer keeps valid and payload as they are
      if (!(in_valid && in_stall)) begin
        if (pending.size() != 0) begin
          offer = $urandom_range(0, 99) >= tx_idle_pct(pending[0].phase);
          // drain point: nothing in flight, nothing transferring now
          if (pending[0].drain && (took || tx_count != rx_count)) offer = 1'b0;
        end
        if (offer) begin
          nxt = pending[0];
          pending.delete(0);
          in_cmd        <= nxt.cmd;
          in_value      <= nxt.value;
          in_hold_mark  <= nxt.hold;
          in_phase_mark <= nxt.phase;
        end
        in_valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer, drives the result-side stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ends_t want;
    logic  stall_nxt;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        rx_count <= rx_count + 1;
        if (ends_due.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          want = ends_due[0];
          ends_due.delete(0);
          check_field("front_value", want.front, out_front_value);
          check_field("back_value", want.back, out_back_value);
          check_field("occupancy", want.occ, out_occupancy);
          check_field("status", want.status, out_status);
        end
      end
      // idle profile follows the command stream; a marked command starts the hold
      if (in_valid && !in_stall) begin
        rx_phase = in_phase_mark;
        if (in_hold_mark) hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_nxt = 1'b1;
      end else begin
        stall_nxt = $urandom_range(0, 99) < rx_idle_pct(rx_phase);
      end
      out_stall <= stall_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transfer means the block hung.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire
